[hw/rtl/wbs_pkg.sv]
// Package with shared constants, types and arithmetic helpers for the waypoint steering block.
`timescale 1ns / 1ps
package wbs_pkg;

   localparam int MAX_WAYPOINTS    = 256;
   localparam int ANGLE_ITERATIONS = 16;
   localparam int WP_IDX_W         = $clog2(MAX_WAYPOINTS);
   localparam int SQRT_STEPS       = 22;
   localparam int ITER_STEPS       = (ANGLE_ITERATIONS > SQRT_STEPS) ? ANGLE_ITERATIONS
                                                                     : SQRT_STEPS;
   localparam int STEP_W           = $clog2(ITER_STEPS + 1);
   localparam int CSR_DATA_W       = 20;
   localparam int CSR_INDEX_W      = 2;

   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_NAV  = 1'b1;

   typedef enum logic [1:0] {
      DRIVE_STOP    = 2'd0,
      DRIVE_FORWARD = 2'd1,
      DRIVE_RIGHT   = 2'd2,
      DRIVE_LEFT    = 2'd3
   } drive_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_WAYPOINT_COUNT  = 2'd0,
      CSR_TURN_THRESHOLD  = 2'd1,
      CSR_ARRIVE_DISTANCE = 2'd2,
      CSR_VALID_RANGE     = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FETCH,
      ST_DIFF,
      ST_SQUARE,
      ST_INIT,
      ST_ITER,
      ST_BEARING,
      ST_UPDATE,
      ST_DECIDE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic              capture;
      logic              mem_write;
      logic              mem_read;
      logic              diff;
      logic              square;
      logic              init;
      logic              sqrt_en;
      logic              cordic_en;
      logic [STEP_W-1:0] step;
      logic              bearing;
      logic              update;
      logic              decide;
      logic              emit;
   } dp_cmd_type;

   // Arctangent of 2^-i in units of 0.01 degree / 65536.
   localparam logic [31:0] ATAN_TABLE [24] = '{
      32'd294912000, 32'd174096719, 32'd91987925, 32'd46694507, 32'd23437865,
      32'd11730358, 32'd5866610, 32'd2933484, 32'd1466765, 32'd733385,
      32'd366693, 32'd183347, 32'd91673, 32'd45837, 32'd22918, 32'd11459,
      32'd5730, 32'd2865, 32'd1432, 32'd716, 32'd358, 32'd179, 32'd90, 32'd45
   };

   // Arithmetic shift right that truncates toward zero.
   function automatic logic signed [33:0] shr_tz(input logic signed [33:0] v,
                                                 input logic [STEP_W-1:0] s);
      logic signed [33:0] n;
      n = -v;
      if (v < 0) begin
         return -(n >>> s);
      end
      return v >>> s;
   endfunction

endpackage

[hw/rtl/wbs_if.sv]
// Valid/ready channel interfaces for the request and response sides.
`timescale 1ns / 1ps
interface wbs_req_if;
   logic               valid;
   logic               ready;
   logic               func;
   logic [7:0]         wp_index;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [15:0] yaw;
   logic               enable;
   logic               fix_stale;

   modport source (output valid, func, wp_index, pos_x, pos_y, yaw, enable, fix_stale,
                   input ready);
   modport sink (input valid, func, wp_index, pos_x, pos_y, yaw, enable, fix_stale,
                 output ready);
endinterface

interface wbs_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         drive_cmd;
   logic signed [15:0] heading_error;
   logic [19:0]        distance_out;
   logic [7:0]         next_waypoint;
   logic               route_done;

   modport source (output valid, drive_cmd, heading_error, distance_out, next_waypoint,
                   route_done, input ready);
   modport sink (input valid, drive_cmd, heading_error, distance_out, next_waypoint,
                 route_done, output ready);
endinterface

[hw/rtl/waypoint_bearing_steering.sv]
// A navigate transaction runs fetch, offsets, squares, init, 22 square-root digit iterations
// that also carry the CORDIC rotations, bearing, update, decide and emit; a disabled tick runs
// only decide and emit. One load per cycle is taken while idle; a navigate holds off requests.
// Reset is synchronous and active high; it clears control, configuration and held state.
// The waypoint table has no reset and must be loaded before use.
`timescale 1ns / 1ps
module waypoint_bearing_steering import wbs_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   wbs_req_if.sink                req_if,
   wbs_rsp_if.source              rsp_if,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   dp_cmd_type cmd;

   wbs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_if.valid),
      .req_func   (req_if.func),
      .req_enable (req_if.enable),
      .req_ready  (req_if.ready),
      .rsp_ready  (rsp_if.ready),
      .rsp_valid  (rsp_if.valid),
      .cmd        (cmd)
   );

   wbs_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_wp_index      (req_if.wp_index),
      .req_pos_x         (req_if.pos_x),
      .req_pos_y         (req_if.pos_y),
      .req_yaw           (req_if.yaw),
      .req_enable        (req_if.enable),
      .req_fix_stale     (req_if.fix_stale),
      .rsp_drive_cmd     (rsp_if.drive_cmd),
      .rsp_heading_error (rsp_if.heading_error),
      .rsp_distance_out  (rsp_if.distance_out),
      .rsp_next_waypoint (rsp_if.next_waypoint),
      .rsp_route_done    (rsp_if.route_done)
   );

endmodule

[hw/rtl/wbs_ctrl.sv]
// Controller state machine that sequences the steering datapath.
`timescale 1ns / 1ps
module wbs_ctrl import wbs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_func,
   input  logic       req_enable,
   output logic       req_ready,
   input  logic       rsp_ready,
   output logic       rsp_valid,
   output dp_cmd_type cmd
);

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      cmd           = '0;
      cmd.step      = step_ff;
      cmd.sqrt_en   = (32'(step_ff) < SQRT_STEPS);
      cmd.cordic_en = (32'(step_ff) < ANGLE_ITERATIONS);
      unique case (state_ff)
         ST_IDLE: begin
            cmd.capture   = accept;
            cmd.mem_write = accept && (req_func == FUNC_LOAD);
            if (accept && req_func == FUNC_NAV) begin
               state_in = req_enable ? ST_FETCH : ST_DECIDE;
            end
         end
         ST_FETCH: begin
            cmd.mem_read = 1'b1;
            state_in     = ST_DIFF;
         end
         ST_DIFF: begin
            cmd.diff = 1'b1;
            state_in = ST_SQUARE;
         end
         ST_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = ST_INIT;
         end
         ST_INIT: begin
            cmd.init = 1'b1;
            step_in  = '0;
            state_in = ST_ITER;
         end
         ST_ITER: begin
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(ITER_STEPS - 1)) begin
               state_in = ST_BEARING;
            end
         end
         ST_BEARING: begin
            cmd.bearing = 1'b1;
            state_in    = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_DECIDE;
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (state_ff != ST_ITER) begin
         cmd.sqrt_en   = 1'b0;
         cmd.cordic_en = 1'b0;
      end
   end

   always_comb begin
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

endmodule

[hw/rtl/wbs_datapath.sv]
// Datapath: waypoint table, offsets, square root, CORDIC bearing and steering decision.
`timescale 1ns / 1ps
module wbs_datapath import wbs_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  dp_cmd_type             cmd,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   input  logic [7:0]             req_wp_index,
   input  logic signed [31:0]     req_pos_x,
   input  logic signed [31:0]     req_pos_y,
   input  logic signed [15:0]     req_yaw,
   input  logic                   req_enable,
   input  logic                   req_fix_stale,
   output logic [1:0]             rsp_drive_cmd,
   output logic signed [15:0]     rsp_heading_error,
   output logic [19:0]            rsp_distance_out,
   output logic [7:0]             rsp_next_waypoint,
   output logic                   rsp_route_done
);

   localparam logic signed [32:0] LIM = 33'sd1048576;

   // Configuration registers.
   logic [7:0]  wp_count_ff;
   logic [14:0] turn_thr_ff;
   logic [15:0] arrive_ff;
   logic [19:0] vrange_ff;

   // Architectural state.
   logic [7:0]         next_index_ff, next_index_in;
   logic signed [15:0] held_error_ff;
   logic [19:0]        held_dist_ff;

   // Captured request.
   logic signed [31:0] px_ff, py_ff;
   logic signed [15:0] yaw_ff;
   logic               enable_ff, stale_ff;

   logic [63:0] wp_mem [MAX_WAYPOINTS];
   logic [63:0] rd_ff;

   logic [19:0] adx_ff, ady_ff;
   logic        dx_neg_ff, dy_neg_ff, dx_zero_ff, dy_zero_ff, in_range_ff;
   logic [39:0] sqx_ff, sqy_ff;

   logic [42:0] op_ff, root_ff, one_ff;
   logic signed [33:0] cx_ff, cy_ff;
   logic signed [31:0] cz_ff;

   logic [15:0] bearing_ff;
   logic [15:0] heading_ff;

   logic [1:0] dec_cmd_ff;
   logic       dec_done_ff;

   logic signed [32:0] dx, dy;
   logic signed [32:0] adx, ady;
   logic [WP_IDX_W-1:0] tgt_addr;
   logic [7:0]  tgt8;
   logic [42:0] trial;
   logic signed [33:0] xs, ys;
   logic signed [31:0] zr;
   logic [16:0] ang;
   logic [15:0] a_clamp;
   logic signed [17:0] hv;
   logic signed [16:0] err;
   logic [20:0] root_dist;
   logic        arrived;
   logic        do_adv;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_count_ff <= 8'd0;
         turn_thr_ff <= 15'd1000;
         arrive_ff   <= 16'd10;
         vrange_ff   <= 20'd20000;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_WAYPOINT_COUNT:  wp_count_ff <= csr_data[7:0];
            CSR_TURN_THRESHOLD:  turn_thr_ff <= csr_data[14:0];
            CSR_ARRIVE_DISTANCE: arrive_ff   <= csr_data[15:0];
            CSR_VALID_RANGE:     vrange_ff   <= csr_data[19:0];
            default: ;
         endcase
      end
   end

   // Waypoint table; the entry of the current target is one below next_index.
   assign tgt8     = next_index_ff - 8'd1;
   assign tgt_addr = tgt8[WP_IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.mem_write && (32'(req_wp_index) < MAX_WAYPOINTS)) begin
         wp_mem[req_wp_index[WP_IDX_W-1:0]] <= {req_pos_x, req_pos_y};
      end
      if (cmd.mem_read) begin
         rd_ff <= wp_mem[tgt_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         px_ff     <= req_pos_x;
         py_ff     <= req_pos_y;
         yaw_ff    <= req_yaw;
         enable_ff <= req_enable;
         stale_ff  <= req_fix_stale;
      end
   end

   // Offsets to the target.
   assign dx  = $signed({rd_ff[63], rd_ff[63:32]}) - $signed({px_ff[31], px_ff});
   assign dy  = $signed({rd_ff[31], rd_ff[31:0]}) - $signed({py_ff[31], py_ff});
   assign adx = dx[32] ? -dx : dx;
   assign ady = dy[32] ? -dy : dy;

   always_ff @(posedge clock) begin
      if (cmd.diff) begin
         adx_ff      <= adx[19:0];
         ady_ff      <= ady[19:0];
         dx_neg_ff   <= dx[32];
         dy_neg_ff   <= dy[32];
         dx_zero_ff  <= (dx == 33'sd0);
         dy_zero_ff  <= (dy == 33'sd0);
         in_range_ff <= (dx > -LIM) && (dx < LIM) && (dy > -LIM) && (dy < LIM);
      end
      if (cmd.square) begin
         sqx_ff <= adx_ff * adx_ff;
         sqy_ff <= ady_ff * ady_ff;
      end
   end

   // One square-root digit per iteration; one CORDIC rotation in each of the first ANGLE_ITERATIONS.
   assign trial = root_ff + one_ff;
   assign xs    = shr_tz(cx_ff, cmd.step);
   assign ys    = shr_tz(cy_ff, cmd.step);

   always_ff @(posedge clock) begin
      if (cmd.init) begin
         op_ff   <= 43'(sqx_ff) + 43'(sqy_ff);
         root_ff <= '0;
         one_ff  <= 43'd1 << 42;
         cx_ff   <= $signed({4'd0, adx_ff, 10'd0});
         cy_ff   <= $signed({4'd0, ady_ff, 10'd0});
         cz_ff   <= '0;
      end else begin
         if (cmd.sqrt_en) begin
            if (op_ff >= trial) begin
               op_ff   <= op_ff - trial;
               root_ff <= (root_ff >> 1) + one_ff;
            end else begin
               root_ff <= root_ff >> 1;
            end
            one_ff <= one_ff >> 2;
         end
         if (cmd.cordic_en) begin
            if (cy_ff > 0) begin
               cx_ff <= cx_ff + ys;
               cy_ff <= cy_ff - xs;
               cz_ff <= cz_ff + $signed(ATAN_TABLE[cmd.step]);
            end else begin
               cx_ff <= cx_ff - ys;
               cy_ff <= cy_ff + xs;
               cz_ff <= cz_ff - $signed(ATAN_TABLE[cmd.step]);
            end
         end
      end
   end

   // Bearing by quadrant and heading from yaw.
   assign zr      = (cz_ff < 0) ? 32'sd0 : cz_ff;
   assign ang     = 17'((zr + 32'sd32768) >>> 16);
   assign a_clamp = (ang > 17'd9000) ? 16'd9000 : ang[15:0];
   assign hv      = -$signed({{2{yaw_ff[15]}}, yaw_ff}) - 18'sd9000;

   always_ff @(posedge clock) begin
      if (cmd.bearing) begin
         if (dx_zero_ff) begin
            bearing_ff <= dy_neg_ff ? 16'd27000 : 16'd9000;
         end else if (dy_zero_ff) begin
            bearing_ff <= dx_neg_ff ? 16'd18000 : 16'd0;
         end else if (!dx_neg_ff && !dy_neg_ff) begin
            bearing_ff <= a_clamp;
         end else if (dx_neg_ff && !dy_neg_ff) begin
            bearing_ff <= 16'd18000 - a_clamp;
         end else if (dx_neg_ff) begin
            bearing_ff <= 16'd18000 + a_clamp;
         end else begin
            bearing_ff <= (a_clamp == 16'd0) ? 16'd0 : 16'd36000 - a_clamp;
         end
         if (hv < -18'sd36000) begin
            heading_ff <= 16'(hv + 18'sd72000);
         end else if (hv < 0) begin
            heading_ff <= 16'(hv + 18'sd36000);
         end else begin
            heading_ff <= hv[15:0];
         end
      end
   end

   // Wrapped error; held values change only for an in-range measurement.
   always_comb begin
      err = $signed({1'b0, bearing_ff}) - $signed({1'b0, heading_ff});
      if (err >= 17'sd18000) begin
         err = err - 17'sd36000;
      end else if (err < -17'sd18000) begin
         err = err + 17'sd36000;
      end
   end
   assign root_dist = root_ff[20:0];

   assign arrived = (held_dist_ff <= {4'd0, arrive_ff}) || stale_ff;
   assign do_adv  = arrived && (next_index_ff < wp_count_ff);
   assign next_index_in = do_adv ? next_index_ff + 8'd1 : next_index_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         next_index_ff <= 8'd2;
         held_error_ff <= '0;
         held_dist_ff  <= '0;
      end else begin
         if (cmd.update && in_range_ff && (root_dist < {1'b0, vrange_ff})) begin
            held_error_ff <= err[15:0];
            held_dist_ff  <= root_dist[19:0];
         end
         if (cmd.decide && enable_ff) begin
            next_index_ff <= next_index_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.decide) begin
         if (!enable_ff) begin
            dec_cmd_ff  <= DRIVE_STOP;
            dec_done_ff <= 1'b0;
         end else if (arrived && next_index_in == wp_count_ff) begin
            dec_cmd_ff  <= DRIVE_STOP;
            dec_done_ff <= 1'b1;
         end else begin
            dec_done_ff <= 1'b0;
            if (held_error_ff > $signed({1'b0, turn_thr_ff})) begin
               dec_cmd_ff <= DRIVE_RIGHT;
            end else if (held_error_ff < -$signed({1'b0, turn_thr_ff})) begin
               dec_cmd_ff <= DRIVE_LEFT;
            end else begin
               dec_cmd_ff <= DRIVE_FORWARD;
            end
         end
      end
      if (cmd.emit) begin
         rsp_drive_cmd     <= dec_cmd_ff;
         rsp_heading_error <= held_error_ff;
         rsp_distance_out  <= held_dist_ff;
         rsp_next_waypoint <= next_index_ff;
         rsp_route_done    <= dec_done_ff;
      end
   end

endmodule

[hw/rtl/wbs_checker.sv]
// Port-level checker for the waypoint steering block, with its bind statement.
`timescale 1ns / 1ps
module wbs_checker import wbs_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               req_func,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [1:0]         rsp_drive_cmd,
   input logic signed [15:0] rsp_heading_error,
   input logic               rsp_route_done
);

   // A stalled response transaction stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // Once a navigate transaction is accepted, the block is not ready in the cycle after.
   a_nav_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_func == FUNC_NAV |=> !req_ready)
      else $error("ready after navigate acceptance");

   // End of route always commands a stop.
   a_done_stop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_route_done |-> rsp_drive_cmd == DRIVE_STOP)
      else $error("route done without stop");

   // The held error is always wrapped.
   a_err_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_heading_error >= -16'sd18000 && rsp_heading_error <= 16'sd17999)
      else $error("heading error out of range");

endmodule

bind waypoint_bearing_steering wbs_checker u_wbs_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_if.valid),
   .req_ready         (req_if.ready),
   .req_func          (req_if.func),
   .rsp_valid         (rsp_if.valid),
   .rsp_ready         (rsp_if.ready),
   .rsp_drive_cmd     (rsp_if.drive_cmd),
   .rsp_heading_error (rsp_if.heading_error),
   .rsp_route_done    (rsp_if.route_done)
);
